// ===== design/variant_candidate_inclusion_filter_defines.svh =====
// ---------------------------------------------------------------------------
// variant_candidate_inclusion_filter_defines
// Assertion macros for the variant candidate inclusion filter.
// ---------------------------------------------------------------------------
`ifndef VARIANT_CANDIDATE_INCLUSION_FILTER_DEFINES_SVH
`define VARIANT_CANDIDATE_INCLUSION_FILTER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define VCIF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vcif assertion failed");

// next-cycle implication
`define VCIF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vcif assertion failed");

`else

`define VCIF_ASSERT_IMPL(label, clk, rst, ante, cons)
`define VCIF_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== design/vcif_pkg.sv =====
// ---------------------------------------------------------------------------
// vcif_pkg
// Types and constants shared by the variant candidate inclusion filter.
// ---------------------------------------------------------------------------
package vcif_pkg;

   localparam int unsigned DEFAULT_MAX_OBS = 1023;

   localparam int QUALITY_W = 12;
   localparam int DEPTH_W   = 16;
   localparam int LENGTH_W  = 10;
   localparam int TOTAL_W   = 22;
   // wide enough for 20 * count and 9 * depth
   localparam int PROD_W    = 22;
   localparam int NUM_THRESH = 4;

   localparam logic [QUALITY_W-1:0] THRESH [NUM_THRESH] = '{
      12'd5, 12'd10, 12'd20, 12'd25
   };

   typedef enum logic [1:0] {
      KIND_SNP = 2'd0,
      KIND_INS = 2'd1,
      KIND_DEL = 2'd2,
      KIND_MNS = 2'd3
   } kind_type;

   typedef struct packed {
      logic fold;
      logic capture;
      logic compare;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } status_type;

endpackage

// ===== design/vcif_req_if.sv =====
// ---------------------------------------------------------------------------
// vcif_req_if
// Observation channel: one beat carries one observation of a candidate.
// ---------------------------------------------------------------------------
interface vcif_req_if;
   import vcif_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [QUALITY_W-1:0] quality;
   logic [1:0]           kind;
   logic [DEPTH_W-1:0]   depth;
   logic [LENGTH_W-1:0]  alt_length;
   logic [LENGTH_W-1:0]  ref_length;
   logic                 last;

   modport source (
      output valid, quality, kind, depth, alt_length, ref_length, last,
      input  ready
   );

   modport sink (
      input  valid, quality, kind, depth, alt_length, ref_length, last,
      output ready
   );
endinterface

// ===== design/vcif_rsp_if.sv =====
// ---------------------------------------------------------------------------
// vcif_rsp_if
// Decision channel: one beat carries the include bit of one candidate.
// ---------------------------------------------------------------------------
interface vcif_rsp_if;
   logic valid;
   logic ready;
   logic include_res;

   modport source (output valid, include_res, input ready);
   modport sink   (input valid, include_res, output ready);
endinterface

// ===== design/vcif_ctrl.sv =====
// ---------------------------------------------------------------------------
// vcif_ctrl
// Sequencer: takes observations, then runs compare and emit for the last one.
// ---------------------------------------------------------------------------
module vcif_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_last,
   output logic                 req_ready,
   input  vcif_pkg::status_type status,
   output vcif_pkg::cmd_type    cmd
);
   import vcif_pkg::*;

   typedef enum logic [2:0] {
      ST_RUN     = 3'b001,
      ST_COMPARE = 3'b010,
      ST_EMIT    = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd         = '0;
      unique case (state_ff)
         ST_RUN: begin
            req_ready   = 1'b1;
            cmd.fold    = req_valid;
            cmd.capture = req_valid && req_last;
            if (req_valid && req_last) begin
               state_in = ST_COMPARE;
            end
         end
         ST_COMPARE: begin
            cmd.compare = 1'b1;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            // hold until the output register can take the decision
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
      end else begin
         state_ff <= state_in;
      end
   end
endmodule

// ===== design/vcif_dp.sv =====
// ---------------------------------------------------------------------------
// vcif_dp
// Datapath: observation statistics, rule compares and the result register.
// ---------------------------------------------------------------------------
module vcif_dp #(
   parameter int unsigned MAX_OBSERVATIONS = vcif_pkg::DEFAULT_MAX_OBS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  vcif_pkg::cmd_type              cmd,
   input  logic [vcif_pkg::QUALITY_W-1:0] quality,
   input  logic [1:0]                     kind,
   input  logic [vcif_pkg::DEPTH_W-1:0]   depth,
   input  logic [vcif_pkg::LENGTH_W-1:0]  alt_length,
   input  logic [vcif_pkg::LENGTH_W-1:0]  ref_length,
   output vcif_pkg::status_type           status,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic                           include_res
);
   import vcif_pkg::*;

   localparam int CNT_W = $clog2(MAX_OBSERVATIONS + 1);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_OBSERVATIONS);

   typedef struct packed {
      logic d_lt4;
      logic d_le15;
      logic d_le30;
      logic d_le60;
      logic n_eq1;
      logic n_gt1;
      logic n_ge3;
      logic n_ge5;
      logic s_ge20;
      logic s_gt100;
      logic s_gt150;
      logic c5_ge2;
      logic c5_x5_gt_d;
      logic c10_ge3;
      logic c10_x5_gt_d;
      logic c20_gt1;
      logic c20_gt3;
      logic c25_gt1;
      logic c25_gt2;
      logic top_snp_lo;
      logic top_snp_hi;
      logic top_gt_alt;
      logic alt_gt8;
      logic n20_gt_d9;
      logic n5_gt_d2;
      logic n20_gt_d7;
      logic n20_gt_d;
      logic ref_lt10;
   } flags_type;

   logic [CNT_W-1:0]     obs_count_ff, obs_count_in;
   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic [QUALITY_W-1:0] best_ff [3];
   logic [QUALITY_W-1:0] best_in [3];
   logic [CNT_W-1:0]     at_least_ff [NUM_THRESH];
   logic [CNT_W-1:0]     at_least_in [NUM_THRESH];

   kind_type            kind_ff;
   logic [DEPTH_W-1:0]  depth_ff;
   logic [LENGTH_W-1:0] alt_ff;
   logic [LENGTH_W-1:0] ref_ff;

   flags_type flags_ff, flags_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      include_ff, include_in;
   logic      decision;
   logic [TOTAL_W:0] sum_wide;

   logic [15:0]       n16, m5, m10, m20, m25;
   logic [PROD_W-1:0] d_ext;
   logic [15:0]       alt_x20;

   // statistics update for one observation
   always_comb begin
      obs_count_in = obs_count_ff;
      total_in     = total_ff;
      best_in      = best_ff;
      at_least_in  = at_least_ff;
      sum_wide     = {1'b0, total_ff} + (TOTAL_W + 1)'(quality);
      if (cmd.emit) begin
         obs_count_in = '0;
         total_in     = '0;
         best_in      = '{default: '0};
         at_least_in  = '{default: '0};
      end else if (cmd.fold) begin
         obs_count_in = (obs_count_ff == CNT_MAX) ? obs_count_ff : obs_count_ff + 1'b1;
         total_in     = sum_wide[TOTAL_W] ? '1 : sum_wide[TOTAL_W-1:0];
         for (int i = 0; i < NUM_THRESH; i++) begin
            if (quality >= THRESH[i] && at_least_ff[i] != CNT_MAX) begin
               at_least_in[i] = at_least_ff[i] + 1'b1;
            end
         end
         // sorted insert into the top three
         if (quality > best_ff[0]) begin
            best_in[2] = best_ff[1];
            best_in[1] = best_ff[0];
            best_in[0] = quality;
         end else if (quality > best_ff[1]) begin
            best_in[2] = best_ff[1];
            best_in[1] = quality;
         end else if (quality > best_ff[2]) begin
            best_in[2] = quality;
         end
      end
   end

   // rule compares, registered ahead of the selection
   always_comb begin
      n16     = 16'(obs_count_ff);
      m5      = 16'(at_least_ff[0]);
      m10     = 16'(at_least_ff[1]);
      m20     = 16'(at_least_ff[2]);
      m25     = 16'(at_least_ff[3]);
      d_ext   = PROD_W'(depth_ff);
      alt_x20 = 16'(alt_ff) * 16'd20;

      flags_in.d_lt4       = depth_ff < 16'd4;
      flags_in.d_le15      = depth_ff <= 16'd15;
      flags_in.d_le30      = depth_ff <= 16'd30;
      flags_in.d_le60      = depth_ff <= 16'd60;
      flags_in.n_eq1       = n16 == 16'd1;
      flags_in.n_gt1       = n16 > 16'd1;
      flags_in.n_ge3       = n16 >= 16'd3;
      flags_in.n_ge5       = n16 >= 16'd5;
      flags_in.s_ge20      = total_ff >= 22'd20;
      flags_in.s_gt100     = total_ff > 22'd100;
      flags_in.s_gt150     = total_ff > 22'd150;
      flags_in.c5_ge2      = m5 >= 16'd2;
      flags_in.c5_x5_gt_d  = PROD_W'(m5) * PROD_W'(5) > d_ext;
      flags_in.c10_ge3     = m10 >= 16'd3;
      flags_in.c10_x5_gt_d = PROD_W'(m10) * PROD_W'(5) > d_ext;
      flags_in.c20_gt1     = m20 > 16'd1;
      flags_in.c20_gt3     = m20 > 16'd3;
      flags_in.c25_gt1     = m25 > 16'd1;
      flags_in.c25_gt2     = m25 > 16'd2;
      flags_in.top_snp_lo  = best_ff[0] >= 12'd20 && best_ff[1] >= 12'd20;
      flags_in.top_snp_hi  = best_ff[0] >= 12'd30 && best_ff[1] >= 12'd25
                             && best_ff[2] >= 12'd20;
      flags_in.top_gt_alt  = 16'(best_ff[0]) > alt_x20;
      flags_in.alt_gt8     = alt_ff > 10'd8;
      flags_in.n20_gt_d9   = PROD_W'(n16) * PROD_W'(20) > d_ext * PROD_W'(9);
      flags_in.n5_gt_d2    = PROD_W'(n16) * PROD_W'(5) > d_ext * PROD_W'(2);
      flags_in.n20_gt_d7   = PROD_W'(n16) * PROD_W'(20) > d_ext * PROD_W'(7);
      flags_in.n20_gt_d    = PROD_W'(n16) * PROD_W'(20) > d_ext;
      flags_in.ref_lt10    = ref_ff < 10'd10;
   end

   // depth-banded rule selection
   always_comb begin
      decision = 1'b0;
      if (flags_ff.d_lt4) begin
         decision = flags_ff.n_gt1 || flags_ff.s_ge20 || kind_ff == KIND_DEL;
      end else begin
         unique case (kind_ff)
            KIND_SNP: begin
               if (flags_ff.d_le60) begin
                  if (!flags_ff.n_gt1)          decision = 1'b0;
                  else if (flags_ff.s_gt100)    decision = 1'b1;
                  else if (!flags_ff.c5_ge2)    decision = 1'b0;
                  else if (flags_ff.c5_x5_gt_d) decision = 1'b1;
                  else                          decision = flags_ff.top_snp_lo;
               end else begin
                  if (!flags_ff.n_ge3)           decision = 1'b0;
                  else if (flags_ff.s_gt150)     decision = 1'b1;
                  else if (!flags_ff.c10_ge3)    decision = 1'b0;
                  else if (flags_ff.c10_x5_gt_d) decision = 1'b1;
                  else                           decision = flags_ff.top_snp_hi;
               end
            end
            KIND_INS: begin
               if (flags_ff.n_eq1 && flags_ff.alt_gt8) decision = 1'b0;
               else if (flags_ff.d_le15) decision = flags_ff.n_gt1;
               else if (flags_ff.d_le30) decision = flags_ff.n20_gt_d9 || flags_ff.n_gt1;
               else if (flags_ff.d_le60) begin
                  if (flags_ff.n_eq1)         decision = 1'b0;
                  else if (flags_ff.n5_gt_d2) decision = 1'b1;
                  else if (!flags_ff.c25_gt1) decision = 1'b0;
                  else if (flags_ff.c25_gt2)  decision = 1'b1;
                  else                        decision = flags_ff.top_gt_alt;
               end else begin
                  if (flags_ff.n_eq1)          decision = 1'b0;
                  else if (flags_ff.n20_gt_d7) decision = 1'b1;
                  else if (!flags_ff.c20_gt1)  decision = 1'b0;
                  else if (flags_ff.c20_gt3)   decision = 1'b1;
                  else                         decision = flags_ff.top_gt_alt;
               end
            end
            KIND_DEL, KIND_MNS: begin
               decision = flags_ff.ref_lt10 ? (flags_ff.n_gt1 && flags_ff.n20_gt_d)
                                            : flags_ff.n_ge5;
            end
            default: begin
               decision = 1'b0;
            end
         endcase
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      include_in   = include_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         include_in   = decision;
      end
   end

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign include_res     = include_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         obs_count_ff <= '0;
         total_ff     <= '0;
         best_ff      <= '{default: '0};
         at_least_ff  <= '{default: '0};
         rsp_valid_ff <= 1'b0;
      end else begin
         obs_count_ff <= obs_count_in;
         total_ff     <= total_in;
         best_ff      <= best_in;
         at_least_ff  <= at_least_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= kind_type'(kind);
         depth_ff <= depth;
         alt_ff   <= alt_length;
         ref_ff   <= ref_length;
      end
      if (cmd.compare) begin
         flags_ff <= flags_in;
      end
      include_ff <= include_in;
   end
endmodule

// ===== design/variant_candidate_inclusion_filter.sv =====
// ---------------------------------------------------------------------------
// variant_candidate_inclusion_filter
// Keeps or rejects a candidate variant from a run of its observations.
// ---------------------------------------------------------------------------
// Observations of one candidate arrive one beat each and are taken one per
// cycle while the block is collecting; each updates the observation count,
// the saturating quality sum, the sorted top three qualities and the
// threshold counts. The beat marked last is folded in the same way, then the
// block stops taking beats: a compare state registers the rule compares, and
// an emit state, once the output register is free, selects the depth-banded
// rule, loads the include bit into the output register and clears the
// statistics. Counts saturate at MAX_OBSERVATIONS.
module variant_candidate_inclusion_filter #(
   parameter int unsigned MAX_OBSERVATIONS = vcif_pkg::DEFAULT_MAX_OBS
) (
   input logic         clock,
   input logic         reset,
   vcif_req_if.sink    req_bus,
   vcif_rsp_if.source  rsp_bus
);
   import vcif_pkg::*;

`include "variant_candidate_inclusion_filter_defines.svh"

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   vcif_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_last  (req_bus.last),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   vcif_dp #(
      .MAX_OBSERVATIONS (MAX_OBSERVATIONS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .quality     (req_bus.quality),
      .kind        (req_bus.kind),
      .depth       (req_bus.depth),
      .alt_length  (req_bus.alt_length),
      .ref_length  (req_bus.ref_length),
      .status      (status),
      .rsp_valid   (rsp_bus.valid),
      .rsp_ready   (rsp_bus.ready),
      .include_res (rsp_bus.include_res)
   );

   assign req_bus.ready = req_ready;

   // no new beat while a decision is in flight
   `VCIF_ASSERT_NEXT(a_stop_after_last, clock, reset, cmd.capture, !req_bus.ready)
   // a pending result is never overwritten
   `VCIF_ASSERT_IMPL(a_emit_only_free, clock, reset, cmd.emit, status.out_free)
   `VCIF_ASSERT_NEXT(a_emit_shows, clock, reset, cmd.emit, rsp_bus.valid)
   `VCIF_ASSERT_IMPL(a_cmd_exclusive, clock, reset, 1'b1,
      $onehot0({cmd.fold, cmd.compare, cmd.emit}))
endmodule
